// ===== src/ltpi_pkg.sv =====
// Shared types and constants for the line/plane intersection block.
// Holds the request and result payloads, status codes and sizing constants.
// No dependencies.
package ltpi_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W = 32;
    localparam int TOL_W = 16;
    localparam int QBITS = 34;
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_INPLANE = 2'd1,
        ST_MISS    = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] line_point_x;
        logic signed [COORD_W-1:0] line_point_y;
        logic signed [COORD_W-1:0] line_point_z;
        logic signed [COORD_W-1:0] line_dir_x;
        logic signed [COORD_W-1:0] line_dir_y;
        logic signed [COORD_W-1:0] line_dir_z;
        logic signed [COORD_W-1:0] plane_normal_x;
        logic signed [COORD_W-1:0] plane_normal_y;
        logic signed [COORD_W-1:0] plane_normal_z;
        logic signed [COORD_W-1:0] plane_point_x;
        logic signed [COORD_W-1:0] plane_point_y;
        logic signed [COORD_W-1:0] plane_point_z;
    } t_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
        t_status                   status;
    } t_res;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p;
        logic [2:0]              neg;
        t_status                 status;
    } t_side;
endpackage

// ===== src/ltpi_front.sv =====
// Front end: dot products, offset, numerator and denominator, classification.
// Three register stages; uses ltpi_pkg.
module ltpi_front #(
    parameter int FRAC_BITS = ltpi_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    input  ltpi_pkg::t_req                                i_req,
    input  logic [ltpi_pkg::TOL_W-1:0]                    i_tolerance,
    output logic [1:0]                                    o_inflight,
    output logic                                          o_valid,
    output ltpi_pkg::t_side                               o_side,
    output logic [2:0][ltpi_pkg::COORD_W-1:0]             o_vmag,
    output logic [64-FRAC_BITS:0]                         o_nmag,
    output logic [64-FRAC_BITS:0]                         o_dmag
);
    import ltpi_pkg::*;

    localparam int DOT_W = 66 - FRAC_BITS;
    localparam int MAG_W = DOT_W - 1;
    localparam int PROD_W = 2 * COORD_W;

    logic signed [COORD_W-1:0] nrm [3];
    logic signed [COORD_W-1:0] pt [3];
    logic signed [COORD_W-1:0] dir [3];
    logic signed [COORD_W-1:0] pq [3];

    logic                      r_v1, r_v2, r_v3;
    logic signed [PROD_W-1:0]  r_pp [3];
    logic signed [PROD_W-1:0]  r_pq [3];
    logic signed [PROD_W-1:0]  r_pv [3];
    logic [2:0][COORD_W-1:0]   r_p1, r_d1, r_p2, r_d2;
    logic signed [DOT_W-1:0]   r_dp, r_dq, r_dv;

    logic signed [DOT_W-1:0]   num, den;
    logic [MAG_W-1:0]          nmag, dmag;
    logic                      den_zero, num_zero;
    logic                      nneg, dneg;

    assign nrm[0] = i_req.plane_normal_x;
    assign nrm[1] = i_req.plane_normal_y;
    assign nrm[2] = i_req.plane_normal_z;
    assign pt[0]  = i_req.line_point_x;
    assign pt[1]  = i_req.line_point_y;
    assign pt[2]  = i_req.line_point_z;
    assign dir[0] = i_req.line_dir_x;
    assign dir[1] = i_req.line_dir_y;
    assign dir[2] = i_req.line_dir_z;
    assign pq[0]  = i_req.plane_point_x;
    assign pq[1]  = i_req.plane_point_y;
    assign pq[2]  = i_req.plane_point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Each product is floored to the fixed-point grid before the sum.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_pp[k]  <= nrm[k] * pt[k];
            r_pq[k]  <= nrm[k] * pq[k];
            r_pv[k]  <= nrm[k] * dir[k];
            r_p1[k]  <= pt[k];
            r_d1[k]  <= dir[k];
        end
        r_dp <= DOT_W'(r_pp[0] >>> FRAC_BITS) + DOT_W'(r_pp[1] >>> FRAC_BITS)
              + DOT_W'(r_pp[2] >>> FRAC_BITS);
        r_dq <= DOT_W'(r_pq[0] >>> FRAC_BITS) + DOT_W'(r_pq[1] >>> FRAC_BITS)
              + DOT_W'(r_pq[2] >>> FRAC_BITS);
        r_dv <= DOT_W'(r_pv[0] >>> FRAC_BITS) + DOT_W'(r_pv[1] >>> FRAC_BITS)
              + DOT_W'(r_pv[2] >>> FRAC_BITS);
        r_p2 <= r_p1;
        r_d2 <= r_d1;
    end

    always_comb begin
        num      = r_dp - r_dq;
        den      = r_dv;
        nneg     = num[DOT_W-1];
        dneg     = den[DOT_W-1];
        nmag     = nneg ? MAG_W'(-num) : MAG_W'(num);
        dmag     = dneg ? MAG_W'(-den) : MAG_W'(den);
        num_zero = (nmag == '0) || (nmag < MAG_W'(i_tolerance));
        den_zero = (dmag == '0) || (dmag < MAG_W'(i_tolerance));
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            o_vmag[k]     <= r_d2[k][COORD_W-1] ? COORD_W'(-r_d2[k]) : r_d2[k];
            o_side.neg[k] <= r_d2[k][COORD_W-1] ^ nneg ^ dneg;
        end
        o_side.p <= r_p2;
        if (!den_zero) begin
            o_side.status <= ST_HIT;
        end else if (num_zero) begin
            o_side.status <= ST_INPLANE;
        end else begin
            o_side.status <= ST_MISS;
        end
        o_nmag <= nmag;
        o_dmag <= dmag;
    end

    assign o_valid    = r_v3;
    assign o_inflight = 2'(r_v1) + 2'(r_v2) + 2'(r_v3);
endmodule

// ===== src/ltpi_fifo.sv =====
// Request queue between the front end and the back end.
// Register array with read and write pointers; uses ltpi_pkg.
module ltpi_fifo #(
    parameter int W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [W-1:0]                  i_data,
    input  logic                          i_pop,
    output logic [W-1:0]                  o_data,
    output logic [ltpi_pkg::QCNT_W-1:0]   o_count
);
    import ltpi_pkg::*;

    logic [W-1:0]        r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;
endmodule

// ===== src/ltpi_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor.
// One quotient bit per stage; uses ltpi_pkg.
module ltpi_div #(
    parameter int MAG_W = 49
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [ltpi_pkg::COORD_W+MAG_W-1:0] i_prod [3],
    input  logic [MAG_W-1:0]                  i_m,
    input  ltpi_pkg::t_side                   i_side,
    output logic                              o_valid,
    output logic [ltpi_pkg::QBITS:0]          o_q [3],
    output ltpi_pkg::t_side                   o_side
);
    import ltpi_pkg::*;

    localparam int PW = COORD_W + MAG_W;

    logic              r_v    [QBITS+1];
    logic [PW-1:0]     r_prod [QBITS+1][3];
    logic [MAG_W-1:0]  r_r    [QBITS+1][3];
    logic [QBITS-1:0]  r_q    [QBITS+1][3];
    logic [2:0]        r_ovf  [QBITS+1];
    logic [MAG_W-1:0]  r_m    [QBITS+1];
    t_side             r_side [QBITS+1];

    logic [MAG_W-1:0]  n_r    [QBITS+1][3];
    logic [QBITS-1:0]  n_q    [QBITS+1][3];
    logic [2:0]        ovf;

    // A quotient of 2^QBITS or more saturates that lane's output anyway.
    for (genvar j = 0; j < 3; j++) begin : g_init
        assign ovf[j]    = MAG_W'(i_prod[j][PW-1:QBITS]) >= i_m;
        assign n_r[0][j] = ovf[j] ? '0 : MAG_W'(i_prod[j][PW-1:QBITS]);
        assign n_q[0][j] = '0;
    end

    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic [MAG_W:0] t;
            logic           ge;
            assign t  = {r_r[k][j], r_prod[k][j][QBITS-1-k]};
            assign ge = t >= {1'b0, r_m[k]};
            assign n_r[k+1][j] = ge ? MAG_W'(t - {1'b0, r_m[k]}) : MAG_W'(t);
            assign n_q[k+1][j] = {r_q[k][j][QBITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QBITS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= QBITS; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0]  <= ovf;
            r_m[0]    <= i_m;
            r_side[0] <= i_side;
            for (int j = 0; j < 3; j++) begin
                r_prod[0][j] <= i_prod[j];
                r_r[0][j]    <= n_r[0][j];
                r_q[0][j]    <= n_q[0][j];
            end
            for (int k = 1; k <= QBITS; k++) begin
                r_ovf[k]  <= r_ovf[k-1];
                r_m[k]    <= r_m[k-1];
                r_side[k] <= r_side[k-1];
                for (int j = 0; j < 3; j++) begin
                    r_prod[k][j] <= r_prod[k-1][j];
                    r_r[k][j]    <= n_r[k][j];
                    r_q[k][j]    <= n_q[k][j];
                end
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_out
        assign o_q[j] = r_ovf[QBITS][j] ? {1'b1, {QBITS{1'b0}}}
                                        : {1'b0, r_q[QBITS][j]};
    end

    assign o_valid = r_v[QBITS];
    assign o_side  = r_side[QBITS];
endmodule

// ===== src/ltpi_back.sv =====
// Back end: offset products, division pipeline, final sum and saturation.
// Advances as one pipeline under the output stall; uses ltpi_pkg and ltpi_div.
module ltpi_back #(
    parameter int FRAC_BITS = ltpi_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_qvalid,
    input  ltpi_pkg::t_side                   i_side,
    input  logic [2:0][ltpi_pkg::COORD_W-1:0] i_vmag,
    input  logic [64-FRAC_BITS:0]             i_nmag,
    input  logic [64-FRAC_BITS:0]             i_dmag,
    input  logic                              i_stall,
    output logic                              o_pop,
    output logic                              o_valid,
    output ltpi_pkg::t_res                    o_res
);
    import ltpi_pkg::*;

    localparam int MAG_W = 65 - FRAC_BITS;
    localparam int PW = COORD_W + MAG_W;
    localparam int H = (MAG_W + 1) / 2;
    localparam int PLO_W = COORD_W + H;
    localparam int PHI_W = COORD_W + MAG_W - H;
    localparam int SUM_W = QBITS + 3;

    logic                      en;
    logic                      r_b1v, r_b2v, r_b3v, r_o_valid;
    t_side                     r_b1s, r_b2s, r_b3s;
    logic [2:0][COORD_W-1:0]   r_b1vm;
    logic [MAG_W-1:0]          r_b1n, r_b1d, r_b2d, r_b3d;
    logic [PLO_W-1:0]          r_plo [3];
    logic [PHI_W-1:0]          r_phi [3];
    logic [PW-1:0]             r_prod [3];
    t_res                      r_res;

    logic                      d_valid;
    logic [QBITS:0]            d_q [3];
    t_side                     d_side;
    logic signed [QBITS+1:0]   s [3];
    logic signed [SUM_W-1:0]   sum [3];
    logic [COORD_W-1:0]        hit [3];

    assign en    = !(r_o_valid && i_stall);
    assign o_pop = en && i_qvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1v     <= 1'b0;
            r_b2v     <= 1'b0;
            r_b3v     <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_b1v     <= i_qvalid;
            r_b2v     <= r_b1v;
            r_b3v     <= r_b2v;
            r_o_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1s  <= i_side;
            r_b1vm <= i_vmag;
            r_b1n  <= i_nmag;
            r_b1d  <= i_dmag;
            for (int j = 0; j < 3; j++) begin
                r_plo[j]  <= r_b1vm[j] * r_b1n[H-1:0];
                r_phi[j]  <= r_b1vm[j] * r_b1n[MAG_W-1:H];
                r_prod[j] <= PW'(r_plo[j]) + (PW'(r_phi[j]) << H);
            end
            r_b2s <= r_b1s;
            r_b2d <= r_b1d;
            r_b3s <= r_b2s;
            r_b3d <= r_b2d;
            r_res <= {hit[0], hit[1], hit[2], d_side.status};
        end
    end

    ltpi_div #(
        .MAG_W (MAG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b3v),
        .i_prod  (r_prod),
        .i_m     (r_b3d),
        .i_side  (r_b3s),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            s[j]   = d_side.neg[j] ? $signed({1'b0, d_q[j]}) : -$signed({1'b0, d_q[j]});
            sum[j] = s[j] + $signed(d_side.p[j]);
            if ((&sum[j][SUM_W-1:COORD_W-1]) || !(|sum[j][SUM_W-1:COORD_W-1])) begin
                hit[j] = sum[j][COORD_W-1:0];
            end else if (sum[j][SUM_W-1]) begin
                hit[j] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                hit[j] = {1'b0, {(COORD_W-1){1'b1}}};
            end
            case (d_side.status)
                ST_HIT:     hit[j] = hit[j];
                ST_INPLANE: hit[j] = d_side.p[j];
                default:    hit[j] = '0;
            endcase
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_res;
endmodule

// ===== src/line_plane_intersection.sv =====
// Line/plane intersection, top level: tolerance register, front end, queue, back end.
// Uses ltpi_pkg, ltpi_front, ltpi_fifo and ltpi_back.
//
//   Port group          Direction  Handshake          Payload
//   request             in         i_valid / o_stall  i_req (t_req)
//   result              out        o_valid / i_stall  o_res (t_res)
//   tolerance register  in         i_cfg_wr_en        i_cfg_wr_data
//
// One request is taken per cycle while o_stall is low; the time from acceptance to a result
// is set mostly by the one-bit-per-stage divider.
// Reset is synchronous and active low; it empties all pipelines and sets tolerance to 1.
// The front end never stops; o_stall rises when the queue has no room beyond what is in flight.
// A stall on the result side while a result is held freezes the back end, which then drains the queue no further.
module line_plane_intersection #(
    parameter int FRAC_BITS = ltpi_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  ltpi_pkg::t_req             i_req,
    output logic                       o_valid,
    input  logic                       i_stall,
    output ltpi_pkg::t_res             o_res,
    input  logic                       i_cfg_wr_en,
    input  logic [ltpi_pkg::TOL_W-1:0] i_cfg_wr_data
);
    import ltpi_pkg::*;

    localparam int MAG_W = 65 - FRAC_BITS;
    localparam int SIDE_W = $bits(t_side);
    localparam int QW = SIDE_W + 3 * COORD_W + 2 * MAG_W;

    logic [TOL_W-1:0]          r_tolerance;
    logic                      accept;
    logic [1:0]                inflight;
    logic                      f_valid;
    t_side                     f_side;
    logic [2:0][COORD_W-1:0]   f_vmag;
    logic [MAG_W-1:0]          f_nmag, f_dmag;
    logic [QW-1:0]             q_out;
    logic [QCNT_W-1:0]         q_count;
    logic                      pop;
    t_side                     b_side;
    logic [2:0][COORD_W-1:0]   b_vmag;
    logic [MAG_W-1:0]          b_nmag, b_dmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_W'(1);
        end else if (i_cfg_wr_en) begin
            r_tolerance <= i_cfg_wr_data;
        end
    end

    assign o_stall = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(inflight)
                     >= (QCNT_W + 1)'(QDEPTH);
    assign accept  = i_valid && !o_stall;

    ltpi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_req       (i_req),
        .i_tolerance (r_tolerance),
        .o_inflight  (inflight),
        .o_valid     (f_valid),
        .o_side      (f_side),
        .o_vmag      (f_vmag),
        .o_nmag      (f_nmag),
        .o_dmag      (f_dmag)
    );

    ltpi_fifo #(
        .W (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_side, f_vmag, f_nmag, f_dmag}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_count (q_count)
    );

    assign {b_side, b_vmag, b_nmag, b_dmag} = q_out;

    ltpi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (q_count != '0),
        .i_side   (b_side),
        .i_vmag   (b_vmag),
        .i_nmag   (b_nmag),
        .i_dmag   (b_dmag),
        .i_stall  (i_stall),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_res    (o_res)
    );

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid && !pop |-> q_count < QCNT_W'(QDEPTH))
        else $error("Queue written while full.");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(inflight) <= (QCNT_W + 1)'(QDEPTH))
        else $error("More requests in flight than the queue can hold.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.status == ST_MISS |->
        o_res.hit_x == '0 && o_res.hit_y == '0 && o_res.hit_z == '0)
        else $error("Parallel miss reported with a nonzero point.");
endmodule

// ===== tb/line_plane_intersection_tb.sv =====
// Testbench for line_plane_intersection: random and directed line/plane requests
// checked against a fixed-point intersection predictor held in a scoreboard class.
// Depends on ltpi_pkg and the line_plane_intersection RTL.
`timescale 1ns / 100ps

module line_plane_intersection_tb;
    import ltpi_pkg::*;

    class hit_scoreboard;
        t_res expected_hits[$];
        int errors;
        logic [15:0] tolerance;

        function new();
            errors = 0;
            tolerance = 16'd1;
        endfunction

        function automatic longint floor_q(longint v);
            return v >>> 16;
        endfunction

        function automatic longint dot(longint a0, longint a1, longint a2,
                                       longint b0, longint b1, longint b2);
            return floor_q(a0 * b0) + floor_q(a1 * b1) + floor_q(a2 * b2);
        endfunction

        function automatic logic [31:0] clamp32(logic signed [127:0] v);
            if (v > 128'sd2147483647) return 32'h7fffffff;
            if (v < -128'sd2147483648) return 32'h80000000;
            return v[31:0];
        endfunction

        function automatic logic [127:0] absval(logic signed [127:0] v);
            return v < 0 ? -v : v;
        endfunction

        function void note_request(t_req r);
            longint p[3], v[3], n[3], q[3];
            logic signed [127:0] num, den, off;
            logic [127:0] mq;
            t_res e;
            p = '{r.line_point_x, r.line_point_y, r.line_point_z};
            v = '{r.line_dir_x, r.line_dir_y, r.line_dir_z};
            n = '{r.plane_normal_x, r.plane_normal_y, r.plane_normal_z};
            q = '{r.plane_point_x, r.plane_point_y, r.plane_point_z};
            num = dot(n[0], n[1], n[2], p[0], p[1], p[2])
                - dot(n[0], n[1], n[2], q[0], q[1], q[2]);
            den = dot(n[0], n[1], n[2], v[0], v[1], v[2]);
            if (den == 0 || absval(den) < tolerance) begin
                if (num == 0 || absval(num) < tolerance) begin
                    e = '{p[0][31:0], p[1][31:0], p[2][31:0], ST_INPLANE};
                end else begin
                    e = '{32'd0, 32'd0, 32'd0, ST_MISS};
                end
            end else begin
                logic [31:0] h[3];
                for (int i = 0; i < 3; i++) begin
                    mq = (absval(v[i]) * absval(num)) / absval(den);
                    if (mq > 128'h100_0000_0000) mq = 128'h100_0000_0000;
                    off = ((v[i] < 0) ^ (num < 0) ^ (den < 0)) ? mq : -mq;
                    h[i] = clamp32(p[i] + off);
                end
                e = '{h[0], h[1], h[2], ST_HIT};
            end
            expected_hits.push_back(e);
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (expected_hits.size() == 0) begin
                $error("result with no request pending");
                errors++;
                return;
            end
            e = expected_hits.pop_front();
            if (got.hit_x !== e.hit_x) begin
                $error("hit_x expected %h actual %h", e.hit_x, got.hit_x); errors++;
            end
            if (got.hit_y !== e.hit_y) begin
                $error("hit_y expected %h actual %h", e.hit_y, got.hit_y); errors++;
            end
            if (got.hit_z !== e.hit_z) begin
                $error("hit_z expected %h actual %h", e.hit_z, got.hit_z); errors++;
            end
            if (got.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, got.status); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0, i_cfg_wr_en = 0;
    logic o_stall, o_valid;
    logic [TOL_W-1:0] i_cfg_wr_data = '0;
    t_req i_req = '0;
    t_res o_res;
    hit_scoreboard sb = new();
    int idle_pct = 25;
    int quiet_cycles = 0;

    line_plane_intersection dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_res);
        if (i_rst_n) i_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles > 20000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            3: return $urandom_range(0, 32'h7ffff) - 32'h40000;
            default: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        r = {12{32'd0}};
        r.line_point_x = pick_coord(); r.line_point_y = pick_coord();
        r.line_point_z = pick_coord();
        r.line_dir_x = pick_coord(); r.line_dir_y = pick_coord(); r.line_dir_z = pick_coord();
        r.plane_normal_x = pick_coord(); r.plane_normal_y = pick_coord();
        r.plane_normal_z = pick_coord();
        r.plane_point_x = pick_coord(); r.plane_point_y = pick_coord();
        r.plane_point_z = pick_coord();
        case ($urandom_range(7))
            0: begin
                r.line_dir_x = 0; r.line_dir_y = 0; r.line_dir_z = 0;
            end
            1: begin
                r.line_dir_x = 0; r.line_dir_y = 0; r.line_dir_z = 0;
                r.plane_point_x = r.line_point_x; r.plane_point_y = r.line_point_y;
                r.plane_point_z = r.line_point_z;
            end
            2: begin
                r.plane_normal_x = 0; r.plane_normal_y = 0;
                r.line_dir_z = $urandom_range(3);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(t_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_req <= r;
        i_valid <= 1;
        sb.note_request(r);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.expected_hits.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [15:0] tol);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= tol;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.tolerance = tol;
    endtask

    initial begin
        t_req r;
        logic [15:0] tols[4] = '{16'd0, 16'hffff, 16'd1, 16'd300};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        r = {12{32'd0}};
        send_request(r);
        r = {12{32'h7fffffff}};
        send_request(r);
        r = {12{32'h80000000}};
        send_request(r);
        r = {12{32'hffffffff}};
        send_request(r);
        r = {12{32'd0}};
        r.plane_normal_z = 32'h10000; r.line_dir_z = 32'h10000;
        r.line_point_z = 32'h30000; r.line_point_x = 32'h7fff0000;
        send_request(r);
        r.line_dir_z = 0;
        send_request(r);
        r.line_point_z = 0;
        send_request(r);
        r.line_dir_z = 1; r.line_dir_x = 32'h80000000; r.line_point_z = 32'h7fffffff;
        send_request(r);
        drain();

        foreach (tols[k]) begin
            write_tolerance(tols[k]);
            for (int i = 0; i < 500; i++) begin
                idle_pct = (k == 2) ? 0 : 25;
                send_request(random_request());
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/ltpi_pkg.sv
src/ltpi_front.sv
src/ltpi_fifo.sv
src/ltpi_div.sv
src/ltpi_back.sv
src/line_plane_intersection.sv
tb/line_plane_intersection_tb.sv
